FILE: sv/mic_pkg.sv
// ----------------------------------------------------------------------------
// mic_pkg
// Shared types and constants for the menu item code parser.
// ----------------------------------------------------------------------------
package mic_pkg;

	// Text bytes beyond this count are dropped
	localparam logic [7:0] TEXT_LIMIT = 8'd255;

	// Style bit masks
	localparam logic [4:0] STYLE_BOLD      = 5'h01;
	localparam logic [4:0] STYLE_ITALIC    = 5'h02;
	localparam logic [4:0] STYLE_UNDERLINE = 5'h04;
	localparam logic [4:0] STYLE_OUTLINE   = 5'h08;
	localparam logic [4:0] STYLE_SHADOW    = 5'h10;

	// Bit 7 marks the alternate command key form
	localparam logic [7:0] ALT_KEY_BIT = 8'h80;

	typedef struct packed {
		logic [7:0] item_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic       char_valid;
		logic [7:0] char_out;
		logic       item_done;
		logic [7:0] cmd_key;
		logic [7:0] mark_out;
		logic [4:0] style_bits;
		logic       is_disabled;
		logic       is_submenu;
		logic [7:0] text_length;
	} out_item_t;

	function automatic logic [4:0] style_of(input logic [7:0] c);
		logic [4:0] s;
		case (c)
			"B":     s = STYLE_BOLD;
			"I":     s = STYLE_ITALIC;
			"U":     s = STYLE_UNDERLINE;
			"O":     s = STYLE_OUTLINE;
			"S":     s = STYLE_SHADOW;
			default: s = 5'h00;
		endcase
		return s;
	endfunction

endpackage

FILE: sv/menu_item_code_parser.sv
// ----------------------------------------------------------------------------
// menu_item_code_parser
// Strips metacharacter codes from a menu item string, one byte per transfer,
// passes text bytes through and reports the item's attributes on its last byte.
// ----------------------------------------------------------------------------
//  channel  | signals                        | carries
//  ---------+--------------------------------+-----------------------------
//  in       | in_valid, in_ready, in_data    | one raw byte + last flag
//  out      | out_valid, out_ready, out_data | cleaned byte + item summary
//
//  One byte per cycle when the output is not stalled: each byte is
//  decoded against the parser state in the cycle it is accepted and its
//  result lands in the output register, shown in the cycle after that.
//  in_ready is high while the output register is empty or being emptied.
//  Reset clears the parser state and the output valid flag.
// ----------------------------------------------------------------------------
module menu_item_code_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mic_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output mic_pkg::out_item_t out_data
);
	import mic_pkg::*;

	typedef enum logic [2:0] {
		CODE_NONE,
		CODE_CMD,
		CODE_ALT,
		CODE_MARK,
		CODE_STYLE
	} code_t;

	code_t      pend_q, pend_d;
	logic       first_q;
	logic       stopped_q, stopped_d;
	logic [7:0] count_q, count_d;
	logic [7:0] cmd_q, cmd_d;
	logic [7:0] mark_q, mark_d;
	logic [4:0] style_q, style_d;
	logic       dis_q, dis_d;
	logic       sub_q, sub_d;

	logic       emit;
	logic [7:0] emit_byte;
	logic       accept;
	logic       last;
	logic [7:0] ch;
	out_item_t  res;
	out_item_t  out_s1;
	logic       out_valid_s1;

	assign ch       = in_data.item_byte;
	assign last     = in_data.last_byte;
	assign in_ready = !out_valid_s1 || out_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		pend_d    = pend_q;
		stopped_d = stopped_q;
		count_d   = count_q;
		cmd_d     = cmd_q;
		mark_d    = mark_q;
		style_d   = style_q;
		dis_d     = dis_q;
		sub_d     = sub_q;
		emit      = 1'b0;
		emit_byte = 8'h00;
		if (stopped_q) begin
			// separator seen: drop the rest of the item
		end else if (pend_q != CODE_NONE) begin
			case (pend_q)
				CODE_CMD:   cmd_d = ch;
				CODE_ALT:   cmd_d = ch | ALT_KEY_BIT;
				CODE_MARK:  mark_d = ch;
				CODE_STYLE: style_d = style_q | style_of(ch);
				default:    ;
			endcase
			pend_d = CODE_NONE;
		end else if (ch == "/" && !last) begin
			pend_d = CODE_CMD;
		end else if (ch == "^" && !last) begin
			pend_d = CODE_ALT;
		end else if (ch == "!" && !last) begin
			pend_d = CODE_MARK;
		end else if (ch == "<" && !last) begin
			pend_d = CODE_STYLE;
		end else if (ch == "(" && first_q) begin
			dis_d = 1'b1;
		end else if (ch == "-" && count_q == 8'd0) begin
			emit      = 1'b1;
			emit_byte = "-";
			count_d   = 8'd1;
			stopped_d = 1'b1;
		end else if (ch == ">") begin
			sub_d = 1'b1;
		end else if (count_q < TEXT_LIMIT) begin
			emit      = 1'b1;
			emit_byte = ch;
			count_d   = count_q + 8'd1;
		end

		res             = '0;
		res.char_valid  = emit;
		res.char_out    = emit_byte;
		if (last) begin
			res.item_done   = 1'b1;
			res.cmd_key     = cmd_d;
			res.mark_out    = mark_d;
			res.style_bits  = style_d;
			res.is_disabled = dis_d;
			res.is_submenu  = sub_d;
			res.text_length = count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= CODE_NONE;
			first_q      <= 1'b1;
			stopped_q    <= 1'b0;
			count_q      <= 8'd0;
			cmd_q        <= 8'd0;
			mark_q       <= 8'd0;
			style_q      <= 5'd0;
			dis_q        <= 1'b0;
			sub_q        <= 1'b0;
			out_valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				out_valid_s1 <= 1'b1;
				if (last) begin
					// item finished: back to the reset state
					pend_q    <= CODE_NONE;
					first_q   <= 1'b1;
					stopped_q <= 1'b0;
					count_q   <= 8'd0;
					cmd_q     <= 8'd0;
					mark_q    <= 8'd0;
					style_q   <= 5'd0;
					dis_q     <= 1'b0;
					sub_q     <= 1'b0;
				end else begin
					pend_q    <= pend_d;
					first_q   <= 1'b0;
					stopped_q <= stopped_d;
					count_q   <= count_d;
					cmd_q     <= cmd_d;
					mark_q    <= mark_d;
					style_q   <= style_d;
					dis_q     <= dis_d;
					sub_q     <= sub_d;
				end
			end else if (out_ready) begin
				out_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_s1 <= res;
		end
	end

	assign out_valid = out_valid_s1;
	assign out_data  = out_s1;

`ifndef NO_ASSERTIONS
	// the separator always leaves exactly one text byte counted
	a_stop_count: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> count_q == 8'd1)
		else $error("stopped with text count other than one");

	// a last byte returns the parser to its reset state
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> first_q && pend_q == CODE_NONE && !stopped_q &&
			count_q == 8'd0)
		else $error("state not cleared after last byte");

	// a stalled result is held
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// summary fields stay zero on results that are not the item's end
	a_summary_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.item_done |-> out_data.cmd_key == 8'd0 &&
			out_data.mark_out == 8'd0 && out_data.text_length == 8'd0)
		else $error("summary set on a non-final result");

	// an emitted byte on the final result is counted
	a_emit_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.item_done && out_data.char_valid |->
			out_data.text_length != 8'd0)
		else $error("final byte emitted but text length is zero");
`endif

endmodule
